// ===== rtl/sparse_ternary_poly_sampler_core_assert.svh =====
// assertion macros for the sparse ternary polynomial sampler
`ifndef SPARSE_TERNARY_POLY_SAMPLER_CORE_ASSERT_SVH
`define SPARSE_TERNARY_POLY_SAMPLER_CORE_ASSERT_SVH

// same-cycle implication, checked on clk, quiet during rst
`define STPS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked on clk, quiet during rst
`define STPS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/stps_pkg.sv =====
// shared types and constants for the sparse ternary polynomial sampler
`timescale 1ns / 1ps

package stps_pkg;

  localparam int POLY_LENGTH = 512;
  localparam int POS_W = $clog2(POLY_LENGTH);
  localparam int CNT_W = 10;
  localparam int CFG_IDX_W = 2;

  localparam logic [CNT_W-1:0] POLY_LEN_CNT = CNT_W'(POLY_LENGTH);
  localparam logic [POS_W-1:0] LAST_ADDR = POS_W'(POLY_LENGTH - 1);

  localparam logic [CNT_W-1:0] ONES_RESET = 10'd154;
  localparam logic [CNT_W-1:0] TWOS_RESET = 10'd0;

  localparam logic KIND_START = 1'b0;
  localparam logic KIND_RAND = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_ONES_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TWOS_COUNT = 2'd1;

  localparam logic signed [2:0] COEFF_ONE = 3'sd1;
  localparam logic signed [2:0] COEFF_TWO = 3'sd2;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_CLEAR = 3'b010,
    ST_CHECK = 3'b100
  } state_t;

  typedef struct packed {
    logic             rd_en;
    logic [POS_W-1:0] rd_addr;
    logic             wr_en;
    logic [POS_W-1:0] wr_addr;
    logic             wr_data;
  } map_req_t;

endpackage

// ===== rtl/stps_map_ram.sv =====
// occupancy map memory, one bit per coefficient, registered read
`timescale 1ns / 1ps

module stps_map_ram (
  input  logic                clk,
  input  stps_pkg::map_req_t  req,
  output logic                rd_data
);

  logic mem [stps_pkg::POLY_LENGTH];

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      rd_data <= mem[req.rd_addr];
    end
  end

endmodule

// ===== rtl/stps_ctrl.sv =====
// placement sequencer: map clear sweep, read-check-mark, counters and result register
`timescale 1ns / 1ps

module stps_ctrl (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  output logic                             busy,
  input  logic                             kind,
  input  logic [7:0]                       rand_first,
  input  logic [7:0]                       rand_second,
  input  logic [stps_pkg::CNT_W-1:0]       ones_target,
  input  logic [stps_pkg::CNT_W-1:0]       twos_target,
  output stps_pkg::map_req_t               map_req,
  input  logic                             map_rd_data,
  output logic                             result_valid,
  output logic [stps_pkg::POS_W-1:0]       position,
  output logic signed [2:0]                coeff_value,
  output logic                             last
);

  stps_pkg::state_t state;
  logic [stps_pkg::POS_W-1:0] clear_addr;
  logic [stps_pkg::CNT_W-1:0] placed_ones;
  logic [stps_pkg::CNT_W-1:0] placed_twos;
  logic finished;
  logic [stps_pkg::POS_W-1:0] pos_q;
  logic neg_q;
  logic mag_two_q;

  logic accept;
  logic [stps_pkg::POS_W-1:0] rand_pos;
  logic need_ones;
  logic need_twos;
  logic [stps_pkg::CNT_W-1:0] placed_ones_next;
  logic [stps_pkg::CNT_W-1:0] placed_twos_next;
  logic done;
  logic signed [2:0] mag;
  logic signed [2:0] coeff_next;
  logic place;

  assign busy = (state != stps_pkg::ST_IDLE);
  assign accept = start && (state == stps_pkg::ST_IDLE);
  assign rand_pos = {rand_second[0], rand_first};
  assign need_ones = (placed_ones < ones_target);
  assign need_twos = (placed_twos < twos_target);
  assign place = (state == stps_pkg::ST_CHECK) && !map_rd_data;

  assign placed_ones_next = placed_ones + stps_pkg::CNT_W'(!mag_two_q);
  assign placed_twos_next = placed_twos + stps_pkg::CNT_W'(mag_two_q);
  assign done = (placed_ones_next >= ones_target) && (placed_twos_next >= twos_target);
  assign mag = mag_two_q ? stps_pkg::COEFF_TWO : stps_pkg::COEFF_ONE;
  assign coeff_next = neg_q ? -mag : mag;

  always_comb begin
    map_req = '0;
    map_req.rd_en = accept && (kind == stps_pkg::KIND_RAND);
    map_req.rd_addr = rand_pos;
    case (state)
      stps_pkg::ST_CLEAR: begin
        map_req.wr_en = 1'b1;
        map_req.wr_addr = clear_addr;
        map_req.wr_data = 1'b0;
      end
      stps_pkg::ST_CHECK: begin
        map_req.wr_en = !map_rd_data;
        map_req.wr_addr = pos_q;
        map_req.wr_data = 1'b1;
      end
      default: begin
        map_req.wr_en = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= stps_pkg::ST_IDLE;
      clear_addr <= '0;
      placed_ones <= '0;
      placed_twos <= '0;
      finished <= 1'b1;
      result_valid <= 1'b0;
    end else begin
      result_valid <= 1'b0;
      case (state)
        stps_pkg::ST_IDLE: begin
          if (accept) begin
            if (kind == stps_pkg::KIND_START) begin
              placed_ones <= '0;
              placed_twos <= '0;
              finished <= (ones_target == '0) && (twos_target == '0);
              clear_addr <= '0;
              state <= stps_pkg::ST_CLEAR;
            end else if (!finished) begin
              if (need_ones || need_twos) begin
                state <= stps_pkg::ST_CHECK;
              end else begin
                finished <= 1'b1;
              end
            end
          end
        end
        stps_pkg::ST_CLEAR: begin
          clear_addr <= clear_addr + 1'b1;
          if (clear_addr == stps_pkg::LAST_ADDR) begin
            state <= stps_pkg::ST_IDLE;
          end
        end
        stps_pkg::ST_CHECK: begin
          state <= stps_pkg::ST_IDLE;
          if (place) begin
            placed_ones <= placed_ones_next;
            placed_twos <= placed_twos_next;
            if (done) begin
              finished <= 1'b1;
            end
            result_valid <= 1'b1;
          end
        end
        default: begin
          state <= stps_pkg::ST_IDLE;
        end
      endcase
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    if (accept) begin
      pos_q <= rand_pos;
      neg_q <= rand_second[1];
      mag_two_q <= !need_ones;
    end
    if (place) begin
      position <= pos_q;
      coeff_value <= coeff_next;
      last <= done;
    end
  end

endmodule

// ===== rtl/sparse_ternary_poly_sampler_core.sv =====
// top level of the sparse ternary polynomial sampler: config registers, clamps, assertions
//
//   channel  signals                                        direction
//   item     start, busy, kind, rand_first, rand_second    in (busy out)
//   config   cfg_valid, cfg_ready, cfg_index, cfg_data     in (cfg_ready out)
//   result   result_valid, position, coeff_value, last     out, one-cycle strobe
//
// a random item that reaches the map goes through a map read, then check and mark
// a random item that is ignored (before start, finished) leaves the block idle
// a start item sweeps the 512-entry map, one entry a cycle, and stays busy until the sweep ends
// the result strobe comes in the cycle after the check, and the next item may already enter
// after rst the block is idle and ignores random items until the first start
// cfg_ready is always high; results cannot be held off
`timescale 1ns / 1ps

module sparse_ternary_poly_sampler_core (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  output logic                                 busy,
  input  logic                                 kind,
  input  logic [7:0]                           rand_first,
  input  logic [7:0]                           rand_second,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [stps_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [stps_pkg::CNT_W-1:0]           cfg_data,
  output logic                                 result_valid,
  output logic [stps_pkg::POS_W-1:0]           position,
  output logic signed [2:0]                    coeff_value,
  output logic                                 last
);

  `include "sparse_ternary_poly_sampler_core_assert.svh"

  logic [stps_pkg::CNT_W-1:0] ones_count;
  logic [stps_pkg::CNT_W-1:0] twos_count;
  logic [stps_pkg::CNT_W-1:0] ones_eff;
  logic [stps_pkg::CNT_W-1:0] room;
  logic [stps_pkg::CNT_W-1:0] twos_eff;
  stps_pkg::map_req_t map_req;
  logic map_rd_data;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      ones_count <= stps_pkg::ONES_RESET;
      twos_count <= stps_pkg::TWOS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        stps_pkg::CFG_ONES_COUNT: ones_count <= cfg_data;
        stps_pkg::CFG_TWOS_COUNT: twos_count <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  assign ones_eff = (ones_count > stps_pkg::POLY_LEN_CNT) ? stps_pkg::POLY_LEN_CNT : ones_count;
  assign room = stps_pkg::POLY_LEN_CNT - ones_eff;
  assign twos_eff = (twos_count > room) ? room : twos_count;

  stps_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .kind         (kind),
    .rand_first   (rand_first),
    .rand_second  (rand_second),
    .ones_target  (ones_eff),
    .twos_target  (twos_eff),
    .map_req      (map_req),
    .map_rd_data  (map_rd_data),
    .result_valid (result_valid),
    .position     (position),
    .coeff_value  (coeff_value),
    .last         (last)
  );

  stps_map_ram u_map (
    .clk     (clk),
    .req     (map_req),
    .rd_data (map_rd_data)
  );

  `STPS_ASSERT_NEXT(a_one_result_per_item, result_valid, !result_valid, "back-to-back results")
  `STPS_ASSERT_NEXT(a_start_sweeps, start && !busy && (kind == stps_pkg::KIND_START), busy, "start did not begin map clear")
  `STPS_ASSERT_NEXT(a_no_early_result, start && !busy, !result_valid, "result right after item transfer")
  `STPS_ASSERT_NOW(a_coeff_legal, result_valid, (coeff_value == 3'sd1) || (coeff_value == -3'sd1) || (coeff_value == 3'sd2) || (coeff_value == -3'sd2), "illegal coefficient")

endmodule

// ===== verif/tb_top.sv =====
// testbench for the sparse ternary polynomial sampler: directed table, full fill, random polynomials
`timescale 1ns / 1ps

module tb_top;

  localparam int ITEM_TARGET = 1000;
  localparam int STALL_LIMIT = 4000;

  localparam logic signed [2:0] PLUS_ONE = stps_pkg::COEFF_ONE;
  localparam logic signed [2:0] MINUS_ONE = -stps_pkg::COEFF_ONE;
  localparam logic signed [2:0] PLUS_TWO = stps_pkg::COEFF_TWO;
  localparam logic signed [2:0] MINUS_TWO = -stps_pkg::COEFF_TWO;

  typedef struct {
    logic [stps_pkg::POS_W-1:0] pos;
    logic signed [2:0]          coeff;
    logic                       lst;
  } placement_t;

  typedef enum logic [1:0] {ROW_ITEM, ROW_SET_ONES, ROW_SET_TWOS} row_op_t;
  typedef enum logic [1:0] {CHK_PREDICT, CHK_NONE, CHK_TYPED} row_chk_t;

  typedef struct {
    row_op_t                    op;
    logic                       kind;
    logic [7:0]                 first;
    logic [7:0]                 second;
    logic [stps_pkg::CNT_W-1:0] setting;
    row_chk_t                   chk;
    logic [stps_pkg::POS_W-1:0] pos;
    logic signed [2:0]          coeff;
    logic                       lst;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst;
  logic start;
  logic busy;
  logic kind;
  logic [7:0] rand_first;
  logic [7:0] rand_second;
  logic cfg_valid;
  logic cfg_ready;
  logic [stps_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [stps_pkg::CNT_W-1:0] cfg_data;
  logic result_valid;
  logic [stps_pkg::POS_W-1:0] position;
  logic signed [2:0] coeff_value;
  logic last;

  sparse_ternary_poly_sampler_core dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .kind(kind),
    .rand_first(rand_first),
    .rand_second(rand_second),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .result_valid(result_valid),
    .position(position),
    .coeff_value(coeff_value),
    .last(last)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor state
  bit                         occupied [stps_pkg::POLY_LENGTH];
  logic [stps_pkg::CNT_W-1:0] ones_placed = '0;
  logic [stps_pkg::CNT_W-1:0] twos_placed = '0;
  logic [stps_pkg::CNT_W-1:0] ones_limit = stps_pkg::ONES_RESET;
  logic [stps_pkg::CNT_W-1:0] twos_limit = stps_pkg::TWOS_RESET;
  bit                         poly_done = 1'b1;

  placement_t placements_due [$];
  placement_t head;
  int         failures = 0;
  int         idle_cycles = 0;
  int         live_items = 0;
  bit         gapless = 1'b0;
  logic [7:0] last_first = '0;
  logic [7:0] last_second = '0;

  stim_row_t directed_rows [24] = '{
    '{ROW_ITEM, stps_pkg::KIND_RAND, 8'hFF, 8'hFF, 10'd0, CHK_NONE, 9'd0, PLUS_ONE, 1'b0},
    '{ROW_ITEM, stps_pkg::KIND_RAND, 8'h00, 8'h00, 10'd0, CHK_NONE, 9'd0, PLUS_ONE, 1'b0},
    '{ROW_ITEM, stps_pkg::KIND_START, 8'hFF, 8'hFF, 10'd0, CHK_NONE, 9'd0, PLUS_ONE, 1'b0},
    '{ROW_ITEM, stps_pkg::KIND_RAND, 8'h00, 8'h00, 10'd0, CHK_TYPED, 9'd0, PLUS_ONE, 1'b0},
    '{ROW_ITEM, stps_pkg::KIND_RAND, 8'hFF, 8'h01, 10'd0, CHK_TYPED, 9'd511, PLUS_ONE, 1'b0},
    '{ROW_ITEM, stps_pkg::KIND_RAND, 8'hFF, 8'hFF, 10'd0, CHK_NONE, 9'd0, PLUS_ONE, 1'b0},
    '{ROW_ITEM, stps_pkg::KIND_RAND, 8'hFE, 8'hFF, 10'd0, CHK_TYPED, 9'd510, MINUS_ONE, 1'b0},
    '{ROW_ITEM, stps_pkg::KIND_RAND, 8'h00, 8'hFC, 10'd0, CHK_NONE, 9'd0, PLUS_ONE, 1'b0},
    '{ROW_ITEM, stps_pkg::KIND_RAND, 8'h80, 8'hFE, 10'd0, CHK_TYPED, 9'd128, MINUS_ONE, 1'b0},
    '{ROW_ITEM, stps_pkg::KIND_RAND, 8'h55, 8'hAA, 10'd0, CHK_PREDICT, 9'd0, PLUS_ONE, 1'b0},
    '{ROW_ITEM, stps_pkg::KIND_RAND, 8'hAA, 8'h55, 10'd0, CHK_PREDICT, 9'd0, PLUS_ONE, 1'b0},
    '{ROW_SET_ONES, stps_pkg::KIND_RAND, 8'h00, 8'h00, 10'd2, CHK_NONE, 9'd0, PLUS_ONE, 1'b0},
    '{ROW_SET_TWOS, stps_pkg::KIND_RAND, 8'h00, 8'h00, 10'd2, CHK_NONE, 9'd0, PLUS_ONE, 1'b0},
    '{ROW_ITEM, stps_pkg::KIND_START, 8'h00, 8'h00, 10'd0, CHK_NONE, 9'd0, PLUS_ONE, 1'b0},
    '{ROW_ITEM, stps_pkg::KIND_RAND, 8'h10, 8'h00, 10'd0, CHK_TYPED, 9'd16, PLUS_ONE, 1'b0},
    '{ROW_ITEM, stps_pkg::KIND_RAND, 8'h11, 8'h02, 10'd0, CHK_TYPED, 9'd17, MINUS_ONE, 1'b0},
    '{ROW_ITEM, stps_pkg::KIND_RAND, 8'h11, 8'h00, 10'd0, CHK_NONE, 9'd0, PLUS_ONE, 1'b0},
    '{ROW_ITEM, stps_pkg::KIND_RAND, 8'h12, 8'h01, 10'd0, CHK_TYPED, 9'd274, PLUS_TWO, 1'b0},
    '{ROW_ITEM, stps_pkg::KIND_RAND, 8'h13, 8'h03, 10'd0, CHK_TYPED, 9'd275, MINUS_TWO, 1'b1},
    '{ROW_ITEM, stps_pkg::KIND_RAND, 8'h14, 8'h00, 10'd0, CHK_NONE, 9'd0, PLUS_ONE, 1'b0},
    '{ROW_SET_ONES, stps_pkg::KIND_RAND, 8'h00, 8'h00, 10'd0, CHK_NONE, 9'd0, PLUS_ONE, 1'b0},
    '{ROW_SET_TWOS, stps_pkg::KIND_RAND, 8'h00, 8'h00, 10'd0, CHK_NONE, 9'd0, PLUS_ONE, 1'b0},
    '{ROW_ITEM, stps_pkg::KIND_START, 8'h5A, 8'hA5, 10'd0, CHK_NONE, 9'd0, PLUS_ONE, 1'b0},
    '{ROW_ITEM, stps_pkg::KIND_RAND, 8'h20, 8'h00, 10'd0, CHK_NONE, 9'd0, PLUS_ONE, 1'b0}
  };

  function automatic logic [stps_pkg::CNT_W-1:0] ones_target();
    return (ones_limit > stps_pkg::POLY_LEN_CNT) ? stps_pkg::POLY_LEN_CNT : ones_limit;
  endfunction

  function automatic logic [stps_pkg::CNT_W-1:0] twos_target();
    logic [stps_pkg::CNT_W-1:0] room;
    room = stps_pkg::POLY_LEN_CNT - ones_target();
    return (twos_limit > room) ? room : twos_limit;
  endfunction

  function automatic void predict_placement(input logic k, input logic [7:0] f,
                                            input logic [7:0] s, output bit produced,
                                            output placement_t p);
    logic [stps_pkg::CNT_W-1:0] t1;
    logic [stps_pkg::CNT_W-1:0] t2;
    logic [stps_pkg::POS_W-1:0] idx;
    bit                         is_two;
    produced = 1'b0;
    p.pos = '0;
    p.coeff = '0;
    p.lst = 1'b0;
    t1 = ones_target();
    t2 = twos_target();
    if (k == stps_pkg::KIND_START) begin
      occupied = '{default: 1'b0};
      ones_placed = '0;
      twos_placed = '0;
      poly_done = (t1 == 0) && (t2 == 0);
      return;
    end
    if (poly_done) return;
    if (ones_placed < t1) begin
      is_two = 1'b0;
    end else if (twos_placed < t2) begin
      is_two = 1'b1;
    end else begin
      poly_done = 1'b1;
      return;
    end
    idx = {s[0], f};
    if (occupied[idx]) return;
    occupied[idx] = 1'b1;
    if (is_two) twos_placed = twos_placed + 1'b1;
    else ones_placed = ones_placed + 1'b1;
    p.pos = idx;
    p.coeff = is_two ? stps_pkg::COEFF_TWO : stps_pkg::COEFF_ONE;
    if (s[1]) p.coeff = -p.coeff;
    p.lst = (ones_placed >= t1) && (twos_placed >= t2);
    if (p.lst) poly_done = 1'b1;
    produced = 1'b1;
  endfunction

  function automatic logic [stps_pkg::CNT_W-1:0] pick_count();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return 10'd1;
      default: return 10'($urandom_range(2, 40));
    endcase
  endfunction

  task automatic send_item(input logic k, input logic [7:0] f, input logic [7:0] s,
                           output bit produced, output placement_t p);
    int gap;
    if ($urandom_range(0, 31) == 0) gapless = !gapless;
    gap = gapless ? 0 : $urandom_range(0, 16);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    kind <= k;
    rand_first <= f;
    rand_second <= s;
    @(posedge clk);
    while (busy) @(posedge clk);
    if (k == stps_pkg::KIND_START || !poly_done) live_items++;
    if (k == stps_pkg::KIND_RAND) begin
      last_first = f;
      last_second = s;
    end
    predict_placement(k, f, s, produced, p);
  endtask

  task automatic feed(input logic k, input logic [7:0] f, input logic [7:0] s);
    bit         produced;
    placement_t p;
    send_item(k, f, s, produced, p);
    if (produced) placements_due.push_back(p);
  endtask

  task automatic settle();
    start <= 1'b0;
    while (placements_due.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic write_reg(input logic [stps_pkg::CFG_IDX_W-1:0] idx,
                           input logic [stps_pkg::CNT_W-1:0] val);
    settle();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    if (idx == stps_pkg::CFG_ONES_COUNT) ones_limit = val;
    else if (idx == stps_pkg::CFG_TWOS_COUNT) twos_limit = val;
  endtask

  always @(posedge clk) begin
    if (!rst && result_valid) begin
      if (placements_due.size() == 0) begin
        $error("unexpected placement at position %0d", position);
        failures++;
      end else begin
        head = placements_due.pop_front();
        if (position !== head.pos) begin
          $error("position: expected %0d, got %0d", head.pos, position);
          failures++;
        end
        if (coeff_value !== head.coeff) begin
          $error("coeff_value: expected %0d, got %0d", head.coeff, coeff_value);
          failures++;
        end
        if (last !== head.lst) begin
          $error("last: expected %0d, got %0d", head.lst, last);
          failures++;
        end
      end
    end
  end

  // stall counter: any transfer on any channel resets it
  always @(posedge clk) begin
    if (rst || (start && !busy) || result_valid || (cfg_valid && cfg_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
  end

  initial begin : watchdog
    while (idle_cycles < STALL_LIMIT) @(posedge clk);
    $display("FAILURE");
    $finish;
  end

  initial begin : stimulus
    stim_row_t                  row;
    bit                         produced;
    placement_t                 guess;
    int                         i;
    int                         j;
    int                         n;
    logic [stps_pkg::POS_W-1:0] pick;
    logic [stps_pkg::POS_W-1:0] fill_order [stps_pkg::POLY_LENGTH];

    rst <= 1'b1;
    start <= 1'b0;
    kind <= stps_pkg::KIND_START;
    rand_first <= '0;
    rand_second <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= stps_pkg::CFG_ONES_COUNT;
    cfg_data <= '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[k]) begin
      row = directed_rows[k];
      case (row.op)
        ROW_SET_ONES: write_reg(stps_pkg::CFG_ONES_COUNT, row.setting);
        ROW_SET_TWOS: write_reg(stps_pkg::CFG_TWOS_COUNT, row.setting);
        default: begin
          send_item(row.kind, row.first, row.second, produced, guess);
          if (row.chk == CHK_PREDICT) begin
            if (produced) placements_due.push_back(guess);
          end else if (row.chk == CHK_TYPED) begin
            guess.pos = row.pos;
            guess.coeff = row.coeff;
            guess.lst = row.lst;
            placements_due.push_back(guess);
          end
        end
      endcase
    end

    // full fill with both counts oversized: every position once, shuffled, with retakes
    write_reg(stps_pkg::CFG_ONES_COUNT, 10'h3FF);
    write_reg(stps_pkg::CFG_TWOS_COUNT, 10'h3FF);
    for (i = 0; i < stps_pkg::POLY_LENGTH; i++) fill_order[i] = stps_pkg::POS_W'(i);
    for (i = stps_pkg::POLY_LENGTH - 1; i > 0; i--) begin
      j = $urandom_range(0, i);
      pick = fill_order[i];
      fill_order[i] = fill_order[j];
      fill_order[j] = pick;
    end
    feed(stps_pkg::KIND_START, 8'($urandom), 8'($urandom));
    i = 0;
    while (!poly_done) begin
      if (i > 0 && $urandom_range(0, 9) == 0) begin
        pick = fill_order[$urandom_range(0, i - 1)];
      end else begin
        pick = fill_order[i];
        i++;
      end
      feed(stps_pkg::KIND_RAND, pick[7:0], {6'($urandom), 1'($urandom), pick[8]});
    end
    feed(stps_pkg::KIND_RAND, 8'($urandom), 8'($urandom));

    while (live_items < ITEM_TARGET) begin
      if ($urandom_range(0, 1) == 1) begin
        write_reg(stps_pkg::CFG_ONES_COUNT, pick_count());
        write_reg(stps_pkg::CFG_TWOS_COUNT, pick_count());
      end else begin
        write_reg(stps_pkg::CFG_TWOS_COUNT, pick_count());
        write_reg(stps_pkg::CFG_ONES_COUNT, pick_count());
      end
      feed(stps_pkg::KIND_START, 8'($urandom), 8'($urandom));
      n = 0;
      while (!poly_done && n < 300) begin
        n++;
        case ($urandom_range(0, 49))
          0: feed(stps_pkg::KIND_START, 8'($urandom), 8'($urandom));
          1: write_reg($urandom_range(0, 1) ? stps_pkg::CFG_ONES_COUNT : stps_pkg::CFG_TWOS_COUNT,
                       pick_count());
          2: settle();
          3, 4, 5, 6, 7, 8, 9, 10, 11:
            feed(stps_pkg::KIND_RAND, last_first, last_second ^ (8'($urandom) & 8'hFE));
          default: feed(stps_pkg::KIND_RAND, 8'($urandom), 8'($urandom));
        endcase
      end
      repeat ($urandom_range(0, 3)) feed(stps_pkg::KIND_RAND, 8'($urandom), 8'($urandom));
    end

    settle();
    repeat (16) @(posedge clk);
    if (failures == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule
